// ----- rtl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Types and constants shared by the per-flow packet statistics block.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int unsigned FlowEntriesDef = 16;
  localparam int unsigned RemapPairsDef  = 4;
  localparam int unsigned NumRegs        = 8;
  localparam int unsigned CfgIdxW        = 4;
  localparam logic [31:0] UsecPerSec     = 32'd1000000;
  localparam logic [31:0] GapMinInit     = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] dst_ip;
    logic [31:0] time_sec;
    logic [19:0] time_usec;
    logic [15:0] pkt_len;
  } pkt_t;

  typedef struct packed {
    logic [31:0] flow_key;
    logic [63:0] packet_count;
    logic [63:0] byte_total;
    logic [63:0] length_square_total;
    logic [15:0] min_length;
    logic [15:0] max_length;
    logic [63:0] gap_total;
    logic [63:0] gap_square_total;
    logic [31:0] min_gap;
    logic [31:0] max_gap;
    logic        table_full;
  } stats_t;

  // one stored flow record (valid and key are kept apart)
  typedef struct packed {
    logic [31:0] last_us;
    logic [63:0] cnt;
    logic [63:0] bytes;
    logic [63:0] len_sq;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [63:0] gap_sum;
    logic [63:0] gap_sq;
    logic [31:0] min_gap;
    logic [31:0] max_gap;
  } rec_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StCalc = 4'b0100,
    StOut  = 4'b1000
  } state_e;

endpackage

// ----- rtl/per_flow_packet_statistics.sv -----
// ----------------------------------------------------------------------------
// per_flow_packet_statistics
// Per-flow packet statistics table with address remap and key CAM.
// ----------------------------------------------------------------------------
// One packet is handled at a time. The pipeline stages are key remap and CAM
// lookup in the accepting cycle, registered record memory read, squaring
// multiplies into registers, then sums and write-back with the result loaded
// into an output register. The input stalls until the result beat has gone,
// so a stalled output also holds the input. The flow record store is a
// synchronous memory of FLOW_ENTRIES rows; keys and valid bits sit in
// flip-flops for the parallel match. A new key with no free row returns
// table_full only.
module per_flow_packet_statistics #(
  parameter int unsigned FLOW_ENTRIES = pfs_pkg::FlowEntriesDef,
  parameter int unsigned REMAP_PAIRS  = pfs_pkg::RemapPairsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pfs_pkg::pkt_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pfs_pkg::stats_t           out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pfs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]               cfg_data_i
);
  import pfs_pkg::*;

  localparam int unsigned IdxW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] regs_q [NumRegs];
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) regs_q[r] <= '0;
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(NumRegs)) begin
      regs_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // remap, lowest pair first
  logic [31:0] key_c;
  always_comb begin
    key_c = in_data_i.dst_ip;
    for (int p = REMAP_PAIRS - 1; p >= 0; p--) begin
      if (regs_q[2*p] == in_data_i.dst_ip) key_c = regs_q[2*p+1];
    end
  end

  // key CAM
  logic [FLOW_ENTRIES-1:0] vld_q;
  logic [31:0]             keys_q [FLOW_ENTRIES];
  logic                    hit_c, free_c;
  logic [IdxW-1:0]         hit_idx_c, free_idx_c;
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hit_idx_c = '0; free_idx_c = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (vld_q[i] && keys_q[i] == key_c) begin
        hit_c = 1'b1; hit_idx_c = IdxW'(i);
      end
      if (!vld_q[i]) begin
        free_c = 1'b1; free_idx_c = IdxW'(i);
      end
    end
  end

  logic            in_acc;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);

  // lookup stage registers
  logic [31:0]     key_q, now_q, gap_c;
  logic [15:0]     len_q;
  logic            hit_q, full_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0]     now_c;
  assign now_c = in_data_i.time_sec * UsecPerSec + 32'(in_data_i.time_usec);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= key_c;
      now_q  <= now_c;
      len_q  <= in_data_i.pkt_len;
      hit_q  <= hit_c;
      full_q <= !hit_c && !free_c;
      idx_q  <= hit_c ? hit_idx_c : free_idx_c;
    end
  end

  // record memory
  rec_t mem_q [FLOW_ENTRIES];
  rec_t rd_q, wr_c;
  logic we_c;
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) rd_q <= mem_q[idx_q];
    if (we_c) mem_q[idx_q] <= wr_c;
  end

  // squares, registered before accumulation
  logic [31:0] len_sq_q;
  logic [63:0] gap_sq_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StCalc) begin
      len_sq_q <= len_q * len_q;
      gap_sq_q <= 64'(gap_c) * 64'(gap_c);
    end
  end
  assign gap_c = now_q - rd_q.last_us;

  // update
  always_comb begin
    wr_c = rd_q;
    wr_c.last_us = now_q;
    if (hit_q) begin
      wr_c.cnt     = rd_q.cnt + 64'd1;
      wr_c.bytes   = rd_q.bytes + 64'(len_q);
      wr_c.len_sq  = rd_q.len_sq + 64'(len_sq_q);
      wr_c.min_len = (len_q < rd_q.min_len) ? len_q : rd_q.min_len;
      wr_c.max_len = (len_q > rd_q.max_len) ? len_q : rd_q.max_len;
      wr_c.gap_sum = rd_q.gap_sum + 64'(gap_c);
      wr_c.gap_sq  = rd_q.gap_sq + gap_sq_q;
      wr_c.min_gap = (gap_c < rd_q.min_gap) ? gap_c : rd_q.min_gap;
      wr_c.max_gap = (gap_c > rd_q.max_gap) ? gap_c : rd_q.max_gap;
    end else begin
      wr_c.cnt     = 64'd1;
      wr_c.bytes   = 64'(len_q);
      wr_c.len_sq  = 64'(len_sq_q);
      wr_c.min_len = len_q;
      wr_c.max_len = len_q;
      wr_c.gap_sum = '0;
      wr_c.gap_sq  = '0;
      wr_c.min_gap = GapMinInit;
      wr_c.max_gap = '0;
    end
  end
  assign we_c = (state_q == StOut) && !out_valid_o && !full_q;

  // valid bits and keys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_c && !hit_q) begin
      vld_q[idx_q] <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (we_c && !hit_q) keys_q[idx_q] <= key_q;
  end

  // output register
  logic   ov_q;
  stats_t od_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && !ov_q) begin
      od_q <= '0;
      if (full_q) begin
        od_q.table_full <= 1'b1;
      end else begin
        od_q.flow_key            <= key_q;
        od_q.packet_count        <= wr_c.cnt;
        od_q.byte_total          <= wr_c.bytes;
        od_q.length_square_total <= wr_c.len_sq;
        od_q.min_length          <= wr_c.min_len;
        od_q.max_length          <= wr_c.max_len;
        od_q.gap_total           <= wr_c.gap_sum;
        od_q.gap_square_total    <= wr_c.gap_sq;
        od_q.min_gap             <= wr_c.min_gap;
        od_q.max_gap             <= wr_c.max_gap;
      end
    end
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StRead;
      StRead: state_d = StCalc;
      StCalc: state_d = StOut;
      StOut:  if (ov_q && !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && !ov_q) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut) else $error("result outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_acc) else $error("accept while busy");
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |-> out_data_o.packet_count == '0)
    else $error("full result carries data");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_c |=> !we_c) else $error("double write");
`endif

endmodule
